// ===== rtl/core/vlrk4_pkg.sv =====
// ----------------------------------------------------------------------------
// vlrk4_pkg
// Shared constants, types and saturation helpers for the RK4 vehicle core.
// ----------------------------------------------------------------------------
package vlrk4_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ADDR_W    = 5;

    // product of two 33-bit signed operands
    localparam int PROD_W    = 66;

    // divide-by-three unit: four quotient bits per cycle
    localparam int DIV_W     = 64 - FRAC_BITS;
    localparam int DIV_STEPS = (DIV_W + 3) / 4;
    localparam int DIV_PAD   = DIV_STEPS * 4;
    localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

    localparam logic signed [PROD_W-1:0] S32_MAX_W = 66'sd2147483647;
    localparam logic signed [PROD_W-1:0] S32_MIN_W = -66'sd2147483648;
    localparam logic signed [PROD_W-1:0] S48_MAX_W = 66'sd140737488355327;
    localparam logic signed [PROD_W-1:0] S48_MIN_W = -66'sd140737488355328;
    localparam logic signed [PROD_W-1:0] HALF_Q    = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] FIVE_Q    = 66'sd5 <<< FRAC_BITS;
    localparam logic signed [PROD_W-1:0] THIRD_RND = 66'sd3 <<< (FRAC_BITS - 1);

    localparam logic [2:0] REG_STEP   = 3'd0;
    localparam logic [2:0] REG_CDEC   = 3'd1;
    localparam logic [2:0] REG_DRAG   = 3'd2;
    localparam logic [2:0] REG_ARES   = 3'd3;
    localparam logic [2:0] REG_THR    = 3'd4;
    localparam logic [2:0] REG_SPD    = 3'd5;
    localparam logic [2:0] REG_SPDSQ  = 3'd6;
    localparam logic [2:0] REG_BRAKE  = 3'd7;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_DRIVE = 2'd1;
    localparam logic [1:0] MODE_BRAKE = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_INIT,
        S_D0, S_D1, S_D2, S_D3, S_D4, S_D5, S_D6, S_D7, S_D8, S_D9, S_DN,
        S_W0, S_W1, S_W2, S_W3, S_W4, S_W5,
        S_FIN, S_DONE
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
        if (x > S32_MAX_W)
            return S32_MAX_W[31:0];
        else if (x < S32_MIN_W)
            return S32_MIN_W[31:0];
        else
            return x[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [PROD_W-1:0] x);
        if (x > S48_MAX_W)
            return S48_MAX_W[47:0];
        else if (x < S48_MIN_W)
            return S48_MIN_W[47:0];
        else
            return x[47:0];
    endfunction

endpackage

// ===== rtl/core/vlrk4_mul.sv =====
// ----------------------------------------------------------------------------
// vlrk4_mul
// Shared signed multiplier with registered product and rounded, saturated
// fixed-point result.
// ----------------------------------------------------------------------------
module vlrk4_mul (
    input  logic                                 clk,
    input  logic signed [32:0]                   a,
    input  logic signed [32:0]                   b,
    output logic signed [vlrk4_pkg::PROD_W-1:0]  prod,
    output logic signed [31:0]                   qm
);
    import vlrk4_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] rnd;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign rnd  = (prod_reg + HALF_Q) >>> FRAC_BITS;
    assign qm   = sat32(rnd);
    assign prod = prod_reg;

endmodule

// ===== rtl/core/vlrk4_div3.sv =====
// ----------------------------------------------------------------------------
// vlrk4_div3
// Iterative unsigned divide by three, four quotient bits per cycle.
// ----------------------------------------------------------------------------
module vlrk4_div3 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [vlrk4_pkg::DIV_PAD-1:0] dividend,
    output logic [vlrk4_pkg::DIV_PAD-1:0] quotient,
    output logic                          done
);
    import vlrk4_pkg::*;

    logic [DIV_PAD-1:0] y_reg, q_reg, y_w, q_w;
    logic [1:0]         r_reg, r_w;
    logic [2:0]         t_w;
    logic [DIV_CW-1:0]  cnt_reg;
    logic               busy_reg, done_reg;

    always_comb
    begin
        r_w = r_reg;
        y_w = y_reg;
        q_w = q_reg;
        t_w = '0;
        for (int k = 0; k < 4; k++)
        begin
            t_w = {r_w, y_w[DIV_PAD-1]};
            y_w = y_w << 1;
            if (t_w >= 3'd3)
            begin
                r_w = 2'(t_w - 3'd3);
                q_w = {q_w[DIV_PAD-2:0], 1'b1};
            end
            else
            begin
                r_w = t_w[1:0];
                q_w = {q_w[DIV_PAD-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CW'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            y_reg <= dividend;
            q_reg <= '0;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            y_reg <= y_w;
            q_reg <= q_w;
            r_reg <= r_w;
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/core/vehicle_longitudinal_rk4_step_core.sv =====
// Each transfer runs five derivative evaluations and eight divide-by-three
// passes that share one multiplier and one iterative divider; modes other
// than drive skip part of each evaluation, and clear mode runs none.
// One transfer at a time: the input stalls until the result is
// registered, and a finished result waits in the output register.
// Reset (async, rst_n low): state and outputs zero, step_size 655.
// ----------------------------------------------------------------------------
// vehicle_longitudinal_rk4_step_core
// One RK4 step of longitudinal vehicle dynamics per input transfer (a clear
// in clear mode), sequenced over a shared multiplier and divide-by-three unit.
// ----------------------------------------------------------------------------
module vehicle_longitudinal_rk4_step_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vlrk4_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [1:0]                    mode,
    input  logic [16:0]                   throttle,
    input  logic [30:0]                   brake_level,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic signed [47:0]            position,
    output logic signed [31:0]            velocity,
    output logic signed [31:0]            acceleration,
    output logic [46:0]                   elapsed_time
);
    import vlrk4_pkg::*;

    state_t state_reg, state_next;

    logic [30:0]        step_reg, drag_reg, ares_reg, brake_reg;
    logic signed [31:0] cdec_reg, thrg_reg, spd_reg, spdsq_reg;

    logic [1:0]         mode_reg;
    logic [16:0]        thr_reg;
    logic [30:0]        brk_reg;
    logic signed [47:0] pos_reg, wp_reg;
    logic signed [31:0] vel_reg, accel_reg, sv_reg, prev_reg, wv_reg, kv_reg;
    logic signed [31:0] tmp_reg, resist_reg, drive_reg;
    logic signed [33:0] racc_reg, dacc_reg;
    logic [46:0]        time_reg;
    logic [1:0]         stage_reg;
    logic               final_reg, sign_reg;

    logic               out_valid_reg;
    logic signed [47:0] out_pos_reg;
    logic signed [31:0] out_vel_reg, out_acc_reg;
    logic [46:0]        out_time_reg;

    logic signed [32:0] mul_a, mul_b, h_w, hh_w, wgt_w, adv_w;
    logic signed [PROD_W-1:0] prod;
    logic signed [31:0] qm, vs_w, dv_w, n1_w, n2_w, net_w;
    logic signed [PROD_W-1:0] abs_w, mag_w, qext_w, sq_w;
    logic [DIV_PAD-1:0] div_in, quot;
    logic               div_start, div_done;
    logic [47:0]        tsum_w;
    logic               wr_en, accept, slot_free;

    vlrk4_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod),
        .qm   (qm)
    );

    vlrk4_div3 u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_in),
        .quotient (quot),
        .done     (div_done)
    );

    // configuration port
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 31'd655;
            cdec_reg  <= '0;
            drag_reg  <= '0;
            ares_reg  <= '0;
            thrg_reg  <= '0;
            spd_reg   <= '0;
            spdsq_reg <= '0;
            brake_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_STEP:  step_reg  <= pwdata[30:0];
                REG_CDEC:  cdec_reg  <= pwdata;
                REG_DRAG:  drag_reg  <= pwdata[30:0];
                REG_ARES:  ares_reg  <= pwdata[30:0];
                REG_THR:   thrg_reg  <= pwdata;
                REG_SPD:   spd_reg   <= pwdata;
                REG_SPDSQ: spdsq_reg <= pwdata;
                REG_BRAKE: brake_reg <= pwdata[30:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_STEP:  prdata = {1'b0, step_reg};
            REG_CDEC:  prdata = cdec_reg;
            REG_DRAG:  prdata = {1'b0, drag_reg};
            REG_ARES:  prdata = {1'b0, ares_reg};
            REG_THR:   prdata = thrg_reg;
            REG_SPD:   prdata = spd_reg;
            REG_SPDSQ: prdata = spdsq_reg;
            REG_BRAKE: prdata = {1'b0, brake_reg};
            default:   prdata = '0;
        endcase
    end

    // datapath helpers
    assign h_w    = $signed({2'b00, step_reg});
    assign hh_w   = $signed({3'b000, step_reg[30:1]});
    assign wgt_w  = (stage_reg == 2'd0 || stage_reg == 2'd3) ? hh_w : h_w;
    assign adv_w  = (stage_reg == 2'd2) ? h_w : hh_w;
    assign vs_w   = sat32(PROD_W'(sv_reg) + FIVE_Q);
    assign dv_w   = sat32(PROD_W'(sv_reg) - PROD_W'(prev_reg));
    assign n1_w   = sat32(PROD_W'(drive_reg) - PROD_W'(resist_reg));
    assign n2_w   = sat32(-PROD_W'(n1_w));
    assign net_w  = sv_reg[31] ? n2_w : n1_w;
    assign abs_w  = prod[PROD_W-1] ? -prod : prod;
    assign mag_w  = abs_w + THIRD_RND;
    assign div_in = mag_w[DIV_PAD+FRAC_BITS-1:FRAC_BITS];
    assign qext_w = $signed(PROD_W'(quot));
    assign sq_w   = sign_reg ? -qext_w : qext_w;
    assign tsum_w = {1'b0, time_reg} + 48'(step_reg);

    assign accept    = item_valid & ~item_stall;
    assign slot_free = ~out_valid_reg | ~result_stall;
    assign div_start = (state_reg == S_W1) || (state_reg == S_W3);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_D0:
            begin
                mul_a = 33'(vs_w);
                mul_b = 33'(vs_w);
            end
            S_D2:
            begin
                mul_a = $signed({2'b00, drag_reg});
                mul_b = 33'(tmp_reg);
            end
            S_D3:
            begin
                mul_a = $signed({2'b00, ares_reg});
                mul_b = 33'(dv_w);
            end
            S_D4:
            begin
                if (mode_reg == MODE_DRIVE)
                begin
                    mul_a = 33'(thrg_reg);
                    mul_b = $signed({16'b0, thr_reg});
                end
                else
                begin
                    mul_a = $signed({2'b00, brake_reg});
                    mul_b = $signed({2'b00, brk_reg});
                end
            end
            S_D5:
            begin
                mul_a = 33'(spd_reg);
                mul_b = 33'(sv_reg);
            end
            S_D6:
            begin
                mul_a = 33'(sv_reg);
                mul_b = 33'(sv_reg);
            end
            S_D8:
            begin
                mul_a = 33'(spdsq_reg);
                mul_b = 33'(tmp_reg);
            end
            S_W0:
            begin
                mul_a = wgt_w;
                mul_b = 33'(sv_reg);
            end
            S_W2:
            begin
                mul_a = wgt_w;
                mul_b = 33'(kv_reg);
            end
            S_W4:
            begin
                mul_a = adv_w;
                mul_b = 33'(kv_reg);
            end
            default: ;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (item_valid) state_next = S_INIT;
            S_INIT: state_next = (mode_reg == MODE_CLEAR) ? S_DONE : S_D0;
            S_D0:   state_next = S_D1;
            S_D1:   state_next = S_D2;
            S_D2:   state_next = S_D3;
            S_D3:   state_next = S_D4;
            S_D4:   state_next = S_D5;
            S_D5:   state_next = (mode_reg == MODE_DRIVE) ? S_D6 : S_DN;
            S_D6:   state_next = S_D7;
            S_D7:   state_next = S_D8;
            S_D8:   state_next = S_D9;
            S_D9:   state_next = S_DN;
            S_DN:   state_next = final_reg ? S_DONE : S_W0;
            S_W0:   state_next = S_W1;
            S_W1:   state_next = S_W2;
            S_W2:   if (div_done) state_next = S_W3;
            S_W3:   state_next = S_W4;
            S_W4:   if (div_done) state_next = (stage_reg == 2'd3) ? S_FIN : S_W5;
            S_W5:   state_next = S_D0;
            S_FIN:  state_next = S_D0;
            S_DONE: if (slot_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        item_stall   = (state_reg != S_IDLE);
        result_valid = out_valid_reg;
        position     = out_pos_reg;
        velocity     = out_vel_reg;
        acceleration = out_acc_reg;
        elapsed_time = out_time_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            vel_reg       <= '0;
            time_reg      <= '0;
            accel_reg     <= '0;
            out_pos_reg   <= '0;
            out_vel_reg   <= '0;
            out_acc_reg   <= '0;
            out_time_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && slot_free)
            begin
                out_valid_reg <= 1'b1;
                out_pos_reg   <= pos_reg;
                out_vel_reg   <= vel_reg;
                out_acc_reg   <= accel_reg;
                out_time_reg  <= time_reg;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_INIT:
                begin
                    if (mode_reg == MODE_CLEAR)
                    begin
                        pos_reg   <= '0;
                        vel_reg   <= '0;
                        time_reg  <= '0;
                        accel_reg <= '0;
                    end
                end
                S_DN:
                begin
                    if (final_reg)
                        accel_reg <= net_w;
                end
                S_FIN:
                begin
                    pos_reg  <= wp_reg;
                    vel_reg  <= wv_reg;
                    time_reg <= tsum_w[47] ? '1 : tsum_w[46:0];
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            thr_reg  <= throttle;
            brk_reg  <= brake_level;
        end
        case (state_reg)
            S_INIT:
            begin
                sv_reg    <= vel_reg;
                prev_reg  <= vel_reg;
                wp_reg    <= pos_reg;
                wv_reg    <= vel_reg;
                stage_reg <= 2'd0;
                final_reg <= 1'b0;
            end
            S_D1: tmp_reg <= qm;
            S_D3: racc_reg <= 34'(cdec_reg) + 34'(qm);
            S_D4: resist_reg <= sat32(PROD_W'(racc_reg) + PROD_W'(qm));
            S_D5:
            begin
                if (mode_reg == MODE_DRIVE)
                    dacc_reg <= 34'(qm);
                else if (mode_reg == MODE_BRAKE)
                    drive_reg <= -qm;
                else
                    drive_reg <= '0;
            end
            S_D6: dacc_reg <= dacc_reg + 34'(qm);
            S_D7: tmp_reg <= qm;
            S_D9: drive_reg <= sat32(PROD_W'(dacc_reg) + PROD_W'(qm));
            S_DN: kv_reg <= net_w;
            S_W1: sign_reg <= prod[PROD_W-1];
            S_W2:
            begin
                if (div_done)
                    wp_reg <= sat48(PROD_W'(wp_reg) + sq_w);
            end
            S_W3: sign_reg <= prod[PROD_W-1];
            S_W4:
            begin
                if (div_done)
                    wv_reg <= sat32(PROD_W'(wv_reg) + sq_w);
            end
            S_W5:
            begin
                prev_reg  <= sv_reg;
                sv_reg    <= sat32(PROD_W'(vel_reg) + PROD_W'(qm));
                stage_reg <= stage_reg + 2'd1;
            end
            S_FIN:
            begin
                prev_reg  <= sv_reg;
                sv_reg    <= wv_reg;
                final_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    a_accept_init: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_INIT)
        else $error("accepted transfer did not start the sequencer");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_W2 || state_reg == S_W4))
        else $error("divider finished outside a wait state");

    a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && slot_free) |=> result_valid && state_reg == S_IDLE)
        else $error("result not loaded on completion");

    a_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_W5 |-> stage_reg != 2'd3)
        else $error("stage advance past the last stage");

endmodule
